// ===== hdl/text_console_char_writer_defines.svh =====
// assertion macros used by the back end of the text console writer rtl
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TCCW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tccw check failed");

// antecedent implies consequent in the next cycle
`define TCCW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tccw check failed");

`endif

// ===== hdl/tccw_pkg.sv =====
// types and constants of the text console character writer
package tccw_pkg;

  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int ENTRY_W     = 16;
  localparam int ADDR_W      = 11;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int LIN_W       = 12;
  localparam int TAB_WIDTH   = 4;
  localparam int BEAT_W      = 2;
  localparam int DATA_W      = 40;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int QDEPTH_DEF  = 4;

  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'd31;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    KIND_PRINT,
    KIND_NEWLINE,
    KIND_BACKSPACE,
    KIND_TAB
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
  } q_item_t;

  typedef struct packed {
    logic               cell_write;
    logic [ADDR_W-1:0]  cell_address;
    logic [ENTRY_W-1:0] cell_entry;
    logic [ADDR_W-1:0]  cursor_position;
    logic               last_of_run;
  } result_t;

endpackage

// ===== hdl/tccw_front.sv =====
// front end: accepts character words and classifies them into queue entries
module tccw_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              q_full,
  output logic              q_push,
  output tccw_pkg::q_item_t q_item
);
  import tccw_pkg::*;

  kind_t kind;

  always_comb begin
    case (char_code)
      CODE_NEWLINE:   kind = KIND_NEWLINE;
      CODE_BACKSPACE: kind = KIND_BACKSPACE;
      CODE_TAB:       kind = KIND_TAB;
      default:        kind = KIND_PRINT;
    endcase
  end

  assign in_ready    = !q_full;
  assign q_push      = in_valid && !q_full;
  assign q_item.kind = kind;
  assign q_item.ch   = (kind == KIND_TAB) ? CODE_SPACE : char_code;

endmodule

// ===== hdl/tccw_queue.sv =====
// short fifo between front end and back end
module tccw_queue #(
  parameter int DEPTH = tccw_pkg::QDEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tccw_pkg::q_item_t item_in,
  output logic              full,
  output logic              valid,
  output tccw_pkg::q_item_t item_out,
  input  logic              pop
);
  import tccw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign item_out = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/tccw_back.sv =====
// back end: cursor state, tab expansion and the registered result word
`include "text_console_char_writer_defines.svh"

module tccw_back #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  logic              q_valid,
  input  tccw_pkg::q_item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tccw_pkg::result_t out_word
);
  import tccw_pkg::*;

  logic [ATTR_W-1:0] colour_attr;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [LIN_W-1:0]  row_base;
  logic [LIN_W-1:0]  lin;
  logic [BEAT_W-1:0] beat;

  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [LIN_W-1:0]  row_base_next;
  logic [LIN_W-1:0]  lin_next;
  result_t           res;
  logic              take;
  logic              fire;
  logic              last_beat;
  logic              row_wrap;

  assign take      = !out_valid || out_ready;
  assign fire      = q_valid && take;
  assign last_beat = (q_item.kind != KIND_TAB) || (beat == BEAT_W'(TAB_WIDTH - 1));
  assign q_pop     = fire && last_beat;
  assign row_wrap  = (row == ROW_W'(ROWS - 1));

  always_comb begin
    row_next           = row;
    col_next           = col;
    row_base_next      = row_base;
    lin_next           = lin;
    res.cell_write     = 1'b1;
    res.cell_address   = lin[ADDR_W-1:0];
    res.cell_entry     = {colour_attr, q_item.ch};
    res.last_of_run    = last_beat;
    case (q_item.kind)
      KIND_NEWLINE: begin
        col_next         = '0;
        row_next         = row_wrap ? '0 : row + 1'b1;
        row_base_next    = row_wrap ? '0 : row_base + LIN_W'(COLUMNS);
        lin_next         = row_base_next;
        res.cell_write   = 1'b0;
        res.cell_address = '0;
        res.cell_entry   = '0;
      end
      KIND_BACKSPACE: begin
        if (col != '0) begin
          col_next = col - 1'b1;
          lin_next = lin - 1'b1;
        end else if (row != '0) begin
          row_next      = row - 1'b1;
          col_next      = COL_W'(COLUMNS - 1);
          row_base_next = row_base - LIN_W'(COLUMNS);
          lin_next      = lin - 1'b1;
        end
        res.cell_address = lin_next[ADDR_W-1:0];
        res.cell_entry   = {colour_attr, CODE_SPACE};
      end
      default: begin
        if (col == COL_W'(COLUMNS - 1)) begin
          col_next      = '0;
          row_next      = row_wrap ? '0 : row + 1'b1;
          row_base_next = row_wrap ? '0 : row_base + LIN_W'(COLUMNS);
          lin_next      = row_base_next;
        end else begin
          col_next = col + 1'b1;
          lin_next = lin + 1'b1;
        end
      end
    endcase
    res.cursor_position = lin_next[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_attr <= ATTR_RESET;
    end else if (cfg_valid) begin
      colour_attr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      row_base  <= '0;
      lin       <= '0;
      beat      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        row      <= row_next;
        col      <= col_next;
        row_base <= row_base_next;
        lin      <= lin_next;
        beat     <= last_beat ? '0 : beat + 1'b1;
      end
      if (take) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= res;
    end
  end

  `TCCW_ASSERT_IMP(a_lin_tracks, clk, rst, 1'b1, lin == row_base + LIN_W'(col))
  `TCCW_ASSERT_IMP(a_cursor_range, clk, rst, 1'b1,
                   (col < COL_W'(COLUMNS)) && (row < ROW_W'(ROWS)))
  `TCCW_ASSERT_IMP(a_beat_in_tab, clk, rst, beat != '0,
                   q_valid && (q_item.kind == KIND_TAB))
  `TCCW_ASSERT_NXT(a_pop_fills_out, clk, rst, q_pop, out_valid && out_word.last_of_run)

endmodule

// ===== hdl/text_console_char_writer.sv =====
// top level of the text console character writer
//
// input stream: one character code per word on s_axis_tdata[7:0]; newline,
// backspace and tab are control codes, every other byte is printed.
// output stream: one word per screen action; tab gives four words, every
// other code gives one, and tlast marks the final word of each character.
// config channel: cfg_data sets the attribute byte placed above each
// character; it is always ready and should be written while the stream idles.
// path: an accepted input word is written into the queue, then moved into the
// output register, where its first result word becomes valid.
// throughput: one output word per cycle while m_axis_tready stays high, set by
// the single back-end cursor update; a tab holds the queue head for four words.
// the queue between front and back end absorbs up to QUEUE_DEPTH input words
// while the receiver stalls; s_axis_tready drops once it is full, and the
// output word holds steady until it is taken.
// reset: cursor goes to the top-left cell, the attribute returns to 31 and
// the queue and output register are emptied.
module text_console_char_writer #(
  parameter int COLUMNS     = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tccw_pkg::ROWS_DEF,
  parameter int QUEUE_DEPTH = tccw_pkg::QDEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // char_code
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // cell_address, cell_entry, cursor_position, zero pad
  output logic [tccw_pkg::DATA_W-1:0] m_axis_tdata,
  output logic [0:0]                  m_axis_tuser,  // cell_write
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_data
);
  import tccw_pkg::*;

  q_item_t push_item;
  q_item_t head_item;
  logic    q_push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t word;

  assign cfg_ready = 1'b1;

  tccw_front u_front (
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .char_code (s_axis_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  tccw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (push_item),
    .full     (q_full),
    .valid    (q_valid),
    .item_out (head_item),
    .pop      (q_pop)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (word)
  );

  assign m_axis_tdata = {2'b00, word.cursor_position, word.cell_entry, word.cell_address};
  assign m_axis_tuser = word.cell_write;
  assign m_axis_tlast = word.last_of_run;

endmodule
